// ===== rtl/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and codes for the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int POS_W = 10;

  typedef logic [1:0]       op_t;
  typedef logic [1:0]       status_t;
  typedef logic [POS_W-1:0] pos_t;

  localparam op_t OP_APPEND = 2'd0;
  localparam op_t OP_SEARCH = 2'd1;
  localparam op_t OP_CLEAR  = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_MISS  = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_ORDER = 2'd3;

endpackage

// ===== rtl/sorted_table_binary_search_top.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Ordered table of signed keys with append, clear and binary search.
// ----------------------------------------------------------------------------
// Append, clear and unused operation codes load their result register in the
// cycle they are accepted. The result is valid on the next cycle, and the
// block takes the next transaction as soon as that result is taken. A search
// probes the single-port table memory, whose read data is registered, so each
// halving step passes through a probe state and a compare state. With
// search_mode 0 a search runs the halving steps, one final probe, the equality
// check and then a done state that loads the result register. With search_mode
// 1 a match ends the search early, and a miss ends once the search range is
// empty. The done state loads the result register only when the output is free.
// The block takes no new transaction while a search runs or while a finished
// result waits on out_tready. The table needs no clearing pass.
module sorted_table_binary_search_top #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,  // search_mode
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((KEY_WIDTH+7)/8)*8-1:0]      in_tdata,     // key
  input  logic [1:0]                          in_tuser,     // operation
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [15:0]                         out_tdata,    // position
  output logic [1:0]                          out_tuser     // status
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = CW + stbs_pkg::POS_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [KEY_WIDTH-1:0] KEY_SIGN = {1'b1, {(KEY_WIDTH-1){1'b0}}};
  localparam logic [CW-1:0]        DEPTH_C  = CW'(TABLE_DEPTH);

  logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0] rd_q;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;

  logic [2:0]             state_r, state_nxt;
  logic                   mode_r;
  logic [CW-1:0]          count_r, count_nxt;
  logic [KEY_WIDTH-1:0]   last_r, last_nxt;
  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [CW-1:0]          lo_r, lo_nxt;
  logic [CW-1:0]          hi_r, hi_nxt;
  logic [CW-1:0]          mid_r, mid_nxt;
  stbs_pkg::status_t      res_status_r, res_status_nxt;
  stbs_pkg::pos_t         res_pos_r, res_pos_nxt;
  logic                   out_valid_r, out_valid_nxt;
  stbs_pkg::status_t      out_status_r, out_status_nxt;
  stbs_pkg::pos_t         out_pos_r, out_pos_nxt;

  logic                 in_acc;
  logic                 out_free;
  logic [KEY_WIDTH-1:0] in_key;
  logic [CW:0]          mid_sum;
  logic [CW-1:0]        mid;
  logic [EW-1:0]        count_ext, mid_ext, lo_ext;

  assign in_key    = in_tdata[KEY_WIDTH-1:0] ^ KEY_SIGN;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r} - {{CW{1'b0}}, mode_r};
  assign mid       = mid_sum[CW:1];
  assign count_ext = {{stbs_pkg::POS_W{1'b0}}, count_r};
  assign mid_ext   = {{stbs_pkg::POS_W{1'b0}}, mid_r};
  assign lo_ext    = {{stbs_pkg::POS_W{1'b0}}, lo_r};

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(16 - stbs_pkg::POS_W){1'b0}}, out_pos_r};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    last_nxt       = last_r;
    key_nxt        = key_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    rd_en          = 1'b0;
    rd_addr        = lo_r[AW-1:0];
    wr_en          = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_pos_nxt = '0;
          case (in_tuser)
            stbs_pkg::OP_APPEND: begin
              out_valid_nxt = 1'b1;
              if (count_r >= DEPTH_C) begin
                out_status_nxt = stbs_pkg::ST_FULL;
              end else if (count_r != '0 && in_key < last_r) begin
                out_status_nxt = stbs_pkg::ST_ORDER;
              end else begin
                wr_en          = 1'b1;
                last_nxt       = in_key;
                count_nxt      = count_r + CW'(1);
                out_status_nxt = stbs_pkg::ST_OK;
                out_pos_nxt    = count_ext[stbs_pkg::POS_W-1:0];
              end
            end
            stbs_pkg::OP_SEARCH: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = stbs_pkg::ST_MISS;
              end else begin
                key_nxt   = in_key;
                lo_nxt    = '0;
                hi_nxt    = mode_r ? count_r : count_r - CW'(1);
                state_nxt = S_PROBE;
              end
            end
            stbs_pkg::OP_CLEAR: begin
              out_valid_nxt  = 1'b1;
              count_nxt      = '0;
              out_status_nxt = stbs_pkg::ST_OK;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = stbs_pkg::ST_MISS;
            end
          endcase
        end
      end
      S_PROBE: begin
        if (lo_r < hi_r) begin
          rd_en     = 1'b1;
          rd_addr   = mid[AW-1:0];
          mid_nxt   = mid;
          state_nxt = S_CMP;
        end else if (!mode_r) begin
          rd_en     = 1'b1;
          state_nxt = S_CHK;
        end else begin
          res_status_nxt = stbs_pkg::ST_MISS;
          res_pos_nxt    = '0;
          state_nxt      = S_DONE;
        end
      end
      S_CMP: begin
        if (mode_r && rd_q == key_r) begin
          res_status_nxt = stbs_pkg::ST_OK;
          res_pos_nxt    = mid_ext[stbs_pkg::POS_W-1:0];
          state_nxt      = S_DONE;
        end else begin
          if (rd_q < key_r) begin
            lo_nxt = mid_r + CW'(1);
          end else begin
            hi_nxt = mid_r;
          end
          state_nxt = S_PROBE;
        end
      end
      S_CHK: begin
        if (rd_q == key_r) begin
          res_status_nxt = stbs_pkg::ST_OK;
          res_pos_nxt    = lo_ext[stbs_pkg::POS_W-1:0];
        end else begin
          res_status_nxt = stbs_pkg::ST_MISS;
          res_pos_nxt    = '0;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pos_nxt    = res_pos_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= in_key;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_r       <= last_nxt;
    key_r        <= key_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
  end

endmodule
